[rtl/core/pca_pkg.sv]
// shared types and codes of the priority channel allocator
package pca_pkg;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_STOP    = 3'd1;
  localparam logic [2:0] ACT_DETACH  = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_ALL     = 3'd4;

  localparam logic [1:0] KIND_STOPPED = 2'd0;
  localparam logic [1:0] KIND_GRANTED = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_KEEP   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] origin;
    logic [8:0]  sound_id;
    logic [7:0]  priority_req;
    logic        once;
    logic [4:0]  channel;
  } item_t;

  typedef struct packed {
    logic [5:0] active;
    logic       keep;
    logic       clear;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [4:0] idx;
    logic [8:0] snd;
    logic       last;
  } res_t;

endpackage

[rtl/core/priority_channel_allocator_unit.sv]
// priority channel allocator: register port, request queue and channel sequencer
// requests are handled by serial scans over the active channels
// the sequencer takes one request at a time, two more may wait in the queue
// results are one-cycle strobes, a start gives up to two, stop all up to one per channel
// reset clears all busy marks, active_channels to 8 (or to CAP if smaller), keep_unsourced to 0
// the receiver cannot stall results
module priority_channel_allocator_unit #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [15:0] origin_i,
  input  logic [8:0]  sound_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic        once_i,
  input  logic [4:0]  channel_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [4:0]  channel_index_o,
  output logic [8:0]  stopped_sound_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pca_pkg::*;

  localparam int CAP = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
  localparam logic [5:0] CAP6 = 6'(CAP);
  localparam logic [5:0] ACT_RST = (CAP < 8) ? CAP6 : 6'd8;

  logic [5:0] act_q;
  logic       keep_q;
  logic       wr, q_valid, pop;
  item_t      item_in, item_q;
  cfg_t       cfg;
  res_t       res;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = (paddr == REG_ACTIVE) ? {26'd0, act_q} :
                  (paddr == REG_KEEP) ? {31'd0, keep_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= ACT_RST;
      keep_q <= 1'b0;
    end else if (wr) begin
      if (!paddr[2]) act_q <= (pwdata[5:0] > CAP6) ? CAP6 : pwdata[5:0];
      else keep_q <= pwdata[0];
    end
  end

  assign cfg = '{active: act_q, keep: keep_q, clear: wr && !paddr[2]};
  assign item_in = '{action: action_i, origin: origin_i, sound_id: sound_id_i,
                     priority_req: priority_req_i, once: once_i, channel: channel_i};

  pca_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .item_i  (item_in),
    .full_o  (busy),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (item_q)
  );

  pca_back #(.CAP(CAP)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (q_valid),
    .item_i  (item_q),
    .pop_o   (pop),
    .res_o   (res)
  );

  assign result_valid_o  = res.valid;
  assign kind_o          = res.kind;
  assign channel_index_o = res.idx;
  assign stopped_sound_o = res.snd;
  assign last_o          = res.last;

endmodule

[rtl/core/pca_front.sv]
// request front end: two-entry queue of accepted requests
module pca_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pca_pkg::item_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pca_pkg::item_t item_o
);
  import pca_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= item_i;
  end

endmodule

[rtl/core/pca_back.sv]
// channel table and scan sequencer
module pca_back #(
  parameter int CAP = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pca_pkg::cfg_t  cfg_i,
  input  logic          valid_i,
  input  pca_pkg::item_t item_i,
  output logic          pop_o,
  output pca_pkg::res_t  res_o
);
  import pca_pkg::*;

  localparam int CW = $clog2(CAP);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ONCE  = 10'b0000000010,
    S_STOP  = 10'b0000000100,
    S_FREE  = 10'b0000001000,
    S_EVICT = 10'b0000010000,
    S_GRANT = 10'b0000100000,
    S_REL   = 10'b0001000000,
    S_ALL   = 10'b0010000000,
    S_DET   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e      st_q, st_d;
  logic [5:0]  c_q, c_d;
  item_t       it_q, it_d;
  logic [CW-1:0] pick_q, pick_d;
  logic [CAP-1:0] busy_q, det_q;
  logic [8:0]  snd_m [CAP];
  logic [7:0]  pri_m [CAP];
  logic [15:0] org_m [CAP];
  logic        pend_v_q;
  logic [1:0]  pend_k_q;
  logic [4:0]  pend_i_q;
  logic [8:0]  pend_s_q;
  res_t        res_q;

  logic [CW-1:0] ci, stop_idx;
  logic        inr, hit, em_v, stop_v, det_v, grant, fin;
  logic [1:0]  em_k;
  logic [4:0]  em_i;
  logic [8:0]  em_s;

  function automatic state_e pre_st(logic [15:0] org, logic keep);
    pre_st = (keep && org == 16'd0) ? S_FREE : S_STOP;
  endfunction

  assign ci  = c_q[CW-1:0];
  assign inr = c_q < cfg_i.active;
  assign hit = busy_q[ci] && !det_q[ci] && org_m[ci] == it_q.origin;
  assign res_o = res_q;

  always_comb begin
    st_d = st_q;
    c_d = c_q;
    it_d = it_q;
    pick_d = pick_q;
    pop_o = 1'b0;
    em_v = 1'b0;
    em_k = KIND_STOPPED;
    stop_idx = ci;
    stop_v = 1'b0;
    det_v = 1'b0;
    grant = 1'b0;
    fin = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          it_d = item_i;
          c_d = 6'd0;
          case (item_i.action)
            ACT_START: begin
              if (item_i.once) st_d = S_ONCE;
              else if (item_i.sound_id == 9'd0) st_d = S_FIN;
              else st_d = pre_st(item_i.origin, cfg_i.keep);
            end
            ACT_STOP:    st_d = S_STOP;
            ACT_DETACH:  st_d = (item_i.origin != 16'd0) ? S_DET : S_FIN;
            ACT_RELEASE: st_d = S_REL;
            ACT_ALL:     st_d = S_ALL;
            default:     st_d = S_FIN;
          endcase
        end
      end
      S_ONCE: begin
        if (!inr) begin
          c_d = 6'd0;
          st_d = (it_q.sound_id == 9'd0) ? S_FIN : pre_st(it_q.origin, cfg_i.keep);
        end else if (hit && snd_m[ci] == it_q.sound_id) begin
          st_d = S_FIN;
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      S_STOP: begin
        if (!inr || hit) begin
          if (inr) begin
            stop_v = 1'b1;
            em_v = 1'b1;
          end
          c_d = 6'd0;
          st_d = (it_q.action == ACT_START) ? S_FREE : S_FIN;
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      S_FREE: begin
        if (!inr) begin
          c_d = 6'd0;
          st_d = S_EVICT;
        end else if (!busy_q[ci]) begin
          pick_d = ci;
          st_d = S_GRANT;
        end else if (it_q.origin != 16'd0 && hit) begin
          stop_v = 1'b1;
          em_v = 1'b1;
          pick_d = ci;
          st_d = S_GRANT;
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      S_EVICT: begin
        if (!inr) begin
          em_v = 1'b1;
          em_k = KIND_REFUSED;
          st_d = S_FIN;
        end else if (pri_m[ci] >= it_q.priority_req) begin
          stop_v = 1'b1;
          em_v = 1'b1;
          pick_d = ci;
          st_d = S_GRANT;
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      S_GRANT: begin
        em_v = 1'b1;
        em_k = KIND_GRANTED;
        grant = 1'b1;
        st_d = S_FIN;
      end
      S_REL: begin
        stop_idx = it_q.channel[CW-1:0];
        if (6'(it_q.channel) < cfg_i.active && busy_q[stop_idx]) begin
          stop_v = 1'b1;
          em_v = 1'b1;
        end
        st_d = S_FIN;
      end
      S_ALL: begin
        if (!inr) begin
          st_d = S_FIN;
        end else begin
          if (busy_q[ci]) begin
            stop_v = 1'b1;
            em_v = 1'b1;
          end
          c_d = c_q + 6'd1;
        end
      end
      S_DET: begin
        if (!inr) begin
          st_d = S_FIN;
        end else if (hit) begin
          det_v = 1'b1;
          st_d = S_FIN;
        end else begin
          c_d = c_q + 6'd1;
        end
      end
      S_FIN: begin
        fin = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (em_k == KIND_STOPPED) begin
      em_i = 5'(stop_idx);
      em_s = snd_m[stop_idx];
    end else if (em_k == KIND_GRANTED) begin
      em_i = 5'(pick_q);
      em_s = 9'd0;
    end else begin
      em_i = 5'd0;
      em_s = 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      c_q      <= 6'd0;
      pick_q   <= '0;
      busy_q   <= '0;
      det_q    <= '0;
      pend_v_q <= 1'b0;
      res_q    <= '0;
    end else begin
      st_q   <= st_d;
      c_q    <= c_d;
      pick_q <= pick_d;
      if (em_v && pend_v_q) begin
        res_q <= '{valid: 1'b1, kind: pend_k_q, idx: pend_i_q, snd: pend_s_q, last: 1'b0};
      end else if (fin && pend_v_q) begin
        res_q <= '{valid: 1'b1, kind: pend_k_q, idx: pend_i_q, snd: pend_s_q, last: 1'b1};
      end else if (fin) begin
        res_q <= '{valid: 1'b1, kind: KIND_NONE, idx: 5'd0, snd: 9'd0, last: 1'b1};
      end else begin
        res_q.valid <= 1'b0;
      end
      if (em_v) begin
        pend_v_q <= 1'b1;
      end else if (fin) begin
        pend_v_q <= 1'b0;
      end
      if (cfg_i.clear) begin
        busy_q <= '0;
      end else begin
        if (stop_v) busy_q[stop_idx] <= 1'b0;
        if (grant) begin
          busy_q[pick_q] <= 1'b1;
          det_q[pick_q]  <= 1'b0;
        end
        if (det_v) det_q[ci] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;
    if (em_v) begin
      pend_k_q <= em_k;
      pend_i_q <= em_i;
      pend_s_q <= em_s;
    end
    if (grant) begin
      snd_m[pick_q] <= it_q.sound_id;
      pri_m[pick_q] <= it_q.priority_req;
      org_m[pick_q] <= it_q.origin;
    end
  end

endmodule
